// ===== rtl/mfs_pkg.sv =====
`default_nettype none

package mfs_pkg;

    localparam logic [7:0] FRAME_MARK = 8'h68;
    localparam logic [7:0] FRAME_END  = 8'h16;
    localparam int         MIN_FRAME  = 12;
    localparam int         SUM_EXTRA  = 10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CS_ERR  = 2'd1;
    localparam logic [1:0] ST_NO_HEAD = 2'd2;
    localparam logic [1:0] ST_NO_END  = 2'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic       is_frame;
        logic [7:0] control_code;
    } t_out;

    typedef enum logic [2:0] {
        RA_POS,
        RA_POS7,
        RA_POS8,
        RA_POS9,
        RA_END,
        RA_CS,
        RA_SUM
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P0,
        S_C0,
        S_C7,
        S_C9,
        S_CEND,
        S_SUM,
        S_CSRD,
        S_CSCHK,
        S_CTRL
    } t_state;

    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       pos_inc;
        t_rd_sel    rd_sel;
        logic       len_ld;
        logic       head_set;
        logic       sum_clr;
        logic       sum_step;
        logic       res_ld;
        logic [1:0] res_status;
    } t_cmd;

    typedef struct packed {
        logic pos_ok;
        logic data_mark;
        logic data_end;
        logic fits;
        logic sum_last;
        logic sum_match;
        logic head;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/mfs_datapath.sv =====
`default_nettype none

module mfs_datapath #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mfs_pkg::t_in  i_in,
    input  wire mfs_pkg::t_cmd i_cmd,
    output mfs_pkg::t_sts      o_sts,
    output logic               o_valid,
    output mfs_pkg::t_out      o_result
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = ((CW > 8) ? CW : 8) + 2;

    logic [7:0]    r_mem [BUFFER_DEPTH];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_pos;
    logic [7:0]    r_len;
    logic [8:0]    r_idx;
    logic [7:0]    r_sum;
    logic          r_pend;
    logic          r_head;
    logic          r_valid;
    mfs_pkg::t_out r_result;

    logic [SW-1:0] pos_w;
    logic [SW-1:0] len_w;
    logic [SW-1:0] cnt_w;
    logic [SW-1:0] addr_w;
    logic [AW-1:0] rd_addr;

    assign pos_w = SW'(r_pos);
    assign len_w = SW'(r_len);
    assign cnt_w = SW'(r_count);

    always_comb begin
        unique case (i_cmd.rd_sel)
            mfs_pkg::RA_POS:  addr_w = pos_w;
            mfs_pkg::RA_POS7: addr_w = pos_w + SW'(7);
            mfs_pkg::RA_POS8: addr_w = pos_w + SW'(8);
            mfs_pkg::RA_POS9: addr_w = pos_w + SW'(9);
            mfs_pkg::RA_END:  addr_w = pos_w + len_w + SW'(mfs_pkg::MIN_FRAME - 1);
            mfs_pkg::RA_CS:   addr_w = pos_w + len_w + SW'(mfs_pkg::SUM_EXTRA);
            mfs_pkg::RA_SUM:  addr_w = pos_w + SW'(r_idx);
            default:          addr_w = pos_w;
        endcase
    end

    assign rd_addr = addr_w[AW-1:0];

    // Store write during loading; the read port is always active.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(BUFFER_DEPTH))) begin
            r_mem[r_count[AW-1:0]] <= i_in.byte_value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_ld;
            r_pend  <= i_cmd.sum_step;
            if (i_cmd.res_ld) begin
                r_count <= '0;
            end else if (i_cmd.load && (r_count < CW'(BUFFER_DEPTH))) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.scan_init) begin
                r_head <= 1'b0;
            end else if (i_cmd.head_set) begin
                r_head <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pos <= '0;
        end else if (i_cmd.pos_inc) begin
            r_pos <= r_pos + CW'(1);
        end
        if (i_cmd.len_ld) begin
            r_len <= r_rd_data;
        end
        // Sum reads are pipelined: the byte read last cycle is added now.
        if (i_cmd.sum_clr) begin
            r_idx <= '0;
            r_sum <= '0;
        end else begin
            if (i_cmd.sum_step) begin
                r_idx <= r_idx + 9'd1;
            end
            if (r_pend) begin
                r_sum <= r_sum + r_rd_data;
            end
        end
        if (i_cmd.res_ld) begin
            r_result.status       <= i_cmd.res_status;
            r_result.is_frame     <= (i_cmd.res_status == mfs_pkg::ST_OK);
            r_result.control_code <= (i_cmd.res_status == mfs_pkg::ST_OK) ? r_rd_data : 8'd0;
        end
    end

    always_comb begin
        o_sts.pos_ok    = (pos_w + SW'(mfs_pkg::MIN_FRAME)) <= cnt_w;
        o_sts.data_mark = (r_rd_data == mfs_pkg::FRAME_MARK);
        o_sts.data_end  = (r_rd_data == mfs_pkg::FRAME_END);
        o_sts.fits      = (pos_w + SW'(r_rd_data) + SW'(mfs_pkg::MIN_FRAME)) <= cnt_w;
        o_sts.sum_last  = (r_idx == (9'(r_len) + 9'(mfs_pkg::SUM_EXTRA - 1)));
        o_sts.sum_match = (r_sum == r_rd_data);
        o_sts.head      = r_head;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/mfs_ctrl.sv =====
`default_nettype none

module mfs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_last,
    input  wire mfs_pkg::t_sts i_sts,
    output logic               o_busy,
    output mfs_pkg::t_cmd      o_cmd
);

    mfs_pkg::t_state r_state;
    mfs_pkg::t_state n_state;

    // High in the first sum cycle only, when the end byte is on the read data.
    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b0;
        end else begin
            r_first <= (r_state == mfs_pkg::S_CEND);
        end
    end

    assign o_busy = (r_state != mfs_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel     = mfs_pkg::RA_POS;
        o_cmd.res_status = mfs_pkg::ST_NO_HEAD;
        unique case (r_state)
            mfs_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.scan_init = 1'b1;
                        n_state = mfs_pkg::S_P0;
                    end
                end
            end
            mfs_pkg::S_P0: begin
                o_cmd.rd_sel = mfs_pkg::RA_POS;
                if (i_sts.pos_ok) begin
                    n_state = mfs_pkg::S_C0;
                end else begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = i_sts.head ? mfs_pkg::ST_NO_END : mfs_pkg::ST_NO_HEAD;
                    n_state = mfs_pkg::S_IDLE;
                end
            end
            mfs_pkg::S_C0: begin
                o_cmd.rd_sel = mfs_pkg::RA_POS7;
                if (i_sts.data_mark) begin
                    n_state = mfs_pkg::S_C7;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = mfs_pkg::S_P0;
                end
            end
            mfs_pkg::S_C7: begin
                o_cmd.rd_sel = mfs_pkg::RA_POS9;
                if (i_sts.data_mark) begin
                    n_state = mfs_pkg::S_C9;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = mfs_pkg::S_P0;
                end
            end
            mfs_pkg::S_C9: begin
                // The length byte is on the read data now.
                o_cmd.len_ld = 1'b1;
                if (i_sts.fits) begin
                    o_cmd.head_set = 1'b1;
                    n_state = mfs_pkg::S_CEND;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = mfs_pkg::S_P0;
                end
            end
            mfs_pkg::S_CEND: begin
                o_cmd.rd_sel = mfs_pkg::RA_END;
                n_state = mfs_pkg::S_SUM;
                o_cmd.sum_clr = 1'b1;
                // The end read is issued here and checked on entry to the sum.
            end
            mfs_pkg::S_SUM: begin
                o_cmd.rd_sel = mfs_pkg::RA_SUM;
                if (r_first && !i_sts.data_end) begin
                    o_cmd.pos_inc = 1'b1;
                    n_state = mfs_pkg::S_P0;
                end else begin
                    o_cmd.sum_step = 1'b1;
                    if (i_sts.sum_last) begin
                        n_state = mfs_pkg::S_CSRD;
                    end
                end
            end
            mfs_pkg::S_CSRD: begin
                o_cmd.rd_sel = mfs_pkg::RA_CS;
                n_state = mfs_pkg::S_CSCHK;
            end
            mfs_pkg::S_CSCHK: begin
                o_cmd.rd_sel = mfs_pkg::RA_POS8;
                if (i_sts.sum_match) begin
                    n_state = mfs_pkg::S_CTRL;
                end else begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = mfs_pkg::ST_CS_ERR;
                    n_state = mfs_pkg::S_IDLE;
                end
            end
            mfs_pkg::S_CTRL: begin
                o_cmd.res_ld     = 1'b1;
                o_cmd.res_status = mfs_pkg::ST_OK;
                n_state = mfs_pkg::S_IDLE;
            end
            default: begin
                n_state = mfs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/meter_frame_search.sv =====
// Meter frame search. Bytes of a receive buffer are loaded one per accepted
// word (start high while busy is low); the word with is_last set starts a
// scan of the stored buffer for a frame of the form 0x68, six address bytes,
// 0x68, control, length L, L data bytes, checksum, 0x16. The block is busy
// from that word until the single result, which appears on o_result for one
// cycle with o_valid high and cannot be held off. The scan runs on the single
// read port of the buffer memory. For each start position in turn it reads the
// first mark, the second mark and the length, then the end byte; it then sums
// the frame bytes and reads the checksum. A failed mark, length or end check
// moves on to the next position; a checksum compare or the position past the
// last one ends the scan, and the result is registered after it. Bytes past
// BUFFER_DEPTH are dropped, though a final byte still starts the scan.
`default_nettype none

module meter_frame_search #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire mfs_pkg::t_in i_in,
    output logic              o_busy,
    output logic              o_valid,
    output mfs_pkg::t_out     o_result
);

    mfs_pkg::t_cmd cmd;
    mfs_pkg::t_sts sts;

    mfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_last  (i_in.is_last),
        .i_sts   (sts),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    mfs_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_frame_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.is_frame == (o_result.status == mfs_pkg::ST_OK)))
        else $error("is_frame disagrees with status");

    a_ctrl_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.is_frame) |-> (o_result.control_code == 8'd0))
        else $error("control code set without a good frame");

    a_one_pulse : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_scan_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.is_last) |=> o_busy)
        else $error("last word did not start a scan");

    a_valid_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result while still scanning");

endmodule

`default_nettype wire
